// ===== rtl/core/waveform_pos_neg_mean_decimator_defines.svh =====
// ----------------------------------------------------------------------------
// waveform pos/neg mean decimator assertion macros
// implication checks on a clock with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_POS_NEG_MEAN_DECIMATOR_DEFINES_SVH
`define WAVEFORM_POS_NEG_MEAN_DECIMATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define WFPNM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfpnm assertion failed");

// next-cycle implication
`define WFPNM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfpnm assertion failed");

`else

`define WFPNM_ASSERT_SAME(label, clk, rst, ante, cons)
`define WFPNM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/wfpnm_pkg.sv =====
// ----------------------------------------------------------------------------
// wfpnm_pkg
// shared widths, constants and types of the waveform pos/neg mean decimator
// ----------------------------------------------------------------------------
package wfpnm_pkg;

  // overview resolution: one block per two columns of the raw stride
  localparam int NUM_BLOCKS  = 2048;
  localparam int BLOCKS      = NUM_BLOCKS / 2;
  localparam int BLOCK_SHIFT = $clog2(BLOCKS);
  localparam int BLK_CNT_W   = $clog2(BLOCKS + 1);

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 16;
  localparam int CFG_W       = 32;
  localparam int BLK_IDX_W   = 11;
  localparam int BSIZE_OUT_W = 21;

  // block size is the register shifted down, counters follow its width
  localparam int CNT_W       = CFG_W - BLOCK_SHIFT;
  localparam int SUM_W       = 40;

  localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = CFG_W'(2048);

  // divider step counter
  localparam int STEP_W      = $clog2(MEAN_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_POS_GO,
    S_POS_DIV,
    S_POS_OUT,
    S_NEG_GO,
    S_NEG_DIV,
    S_NEG_OUT
  } state_t;

  // divider request and status
  typedef struct packed {
    logic start;
    logic negate;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/waveform_pos_neg_mean_decimator.sv =====
// ----------------------------------------------------------------------------
// waveform_pos_neg_mean_decimator
// per-block means of non-negative and negative samples for a waveform overview
// ----------------------------------------------------------------------------
//
//  channel  signals                                        direction
//  -------  ---------------------------------------------  ---------
//  cfg      cfg_valid cfg_ready cfg_data                   in
//  in       in_valid in_ready sample first                 in
//  out      out_valid out_ready mean is_negative_half      out
//           block_index block_size_out last waveform_done
//
//  a sample that does not close a block is accepted, then accumulated
//  a closing sample also yields both means, held back by output stalls: both means go
//  through the one restoring divider, 16 quotient bits each, then wait for out_ready
//  samples after the final block are accepted and dropped
//  synchronous reset restores sample_count to 2048 and clears all progress
//  in_ready and cfg_ready are low while a sample is processed or a mean waits
//
module waveform_pos_neg_mean_decimator import wfpnm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_W-1:0]       cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_W-1:0]    sample,
  input  logic                          first,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [MEAN_W-1:0]      mean,
  output logic                          is_negative_half,
  output logic        [BLK_IDX_W-1:0]   block_index,
  output logic        [BSIZE_OUT_W-1:0] block_size_out,
  output logic                          last,
  output logic                          waveform_done
);

`include "waveform_pos_neg_mean_decimator_defines.svh"

  state_t state, state_next;

  logic        [CFG_W-1:0]     sample_count;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic                        first_r;

  logic signed [SUM_W-1:0]     positive_sum;
  logic signed [SUM_W-1:0]     negative_sum;
  logic        [CNT_W-1:0]     positive_count;
  logic        [CNT_W-1:0]     negative_count;
  logic        [CNT_W-1:0]     samples_in_block;
  logic        [BLK_CNT_W-1:0] blocks_done;

  logic signed [SUM_W-1:0]     positive_sum_next;
  logic signed [SUM_W-1:0]     negative_sum_next;
  logic        [CNT_W-1:0]     positive_count_next;
  logic        [CNT_W-1:0]     negative_count_next;
  logic        [CNT_W-1:0]     samples_in_block_next;
  logic        [BLK_CNT_W-1:0] blocks_done_next;

  logic signed [SUM_W-1:0]     pos_base;
  logic signed [SUM_W-1:0]     neg_base;
  logic        [CNT_W-1:0]     pos_cnt_base;
  logic        [CNT_W-1:0]     neg_cnt_base;
  logic        [CNT_W-1:0]     sib_base;
  logic        [BLK_CNT_W-1:0] blk_base;
  logic signed [SUM_W-1:0]     sample_ext;

  logic        [CNT_W-1:0]     bsize_raw;
  logic        [CNT_W-1:0]     bsize;

  div_req_t                    div_req;
  div_stat_t                   div_stat;
  logic signed [SUM_W-1:0]     div_dividend;
  logic        [CNT_W-1:0]     div_divisor;
  logic signed [MEAN_W-1:0]    div_result;

  logic                        out_xfer;

  // block size from the register, zero quotient counts as one
  assign bsize_raw = sample_count[CFG_W-1:BLOCK_SHIFT];
  assign bsize     = (bsize_raw == '0) ? CNT_W'(1) : bsize_raw;

  // configuration register, written only between samples
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      sample_count <= cfg_data;
    end
  end

  // input holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= sample;
      first_r  <= first;
    end
  end

  // accumulation: first flag clears progress before the sample is added
  always_comb begin
    pos_base     = first_r ? '0 : positive_sum;
    neg_base     = first_r ? '0 : negative_sum;
    pos_cnt_base = first_r ? '0 : positive_count;
    neg_cnt_base = first_r ? '0 : negative_count;
    sib_base     = first_r ? '0 : samples_in_block;
    blk_base     = first_r ? '0 : blocks_done;
    sample_ext   = {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};

    positive_sum_next     = positive_sum;
    negative_sum_next     = negative_sum;
    positive_count_next   = positive_count;
    negative_count_next   = negative_count;
    samples_in_block_next = samples_in_block;
    blocks_done_next      = blocks_done;

    if (state == S_ACCUM) begin
      positive_sum_next     = pos_base;
      negative_sum_next     = neg_base;
      positive_count_next   = pos_cnt_base;
      negative_count_next   = neg_cnt_base;
      samples_in_block_next = sib_base;
      blocks_done_next      = blk_base;
      if (blk_base < BLK_CNT_W'(BLOCKS)) begin
        if (!sample_r[SAMPLE_W-1]) begin
          positive_sum_next   = pos_base + sample_ext;
          positive_count_next = pos_cnt_base + CNT_W'(1);
        end else begin
          negative_sum_next   = neg_base + sample_ext;
          negative_count_next = neg_cnt_base + CNT_W'(1);
        end
        samples_in_block_next = sib_base + CNT_W'(1);
      end
    end else if ((state == S_NEG_OUT) && out_ready) begin
      // block closed: clear and move on
      positive_sum_next     = '0;
      negative_sum_next     = '0;
      positive_count_next   = '0;
      negative_count_next   = '0;
      samples_in_block_next = '0;
      blocks_done_next      = blocks_done + BLK_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_sum     <= '0;
      negative_sum     <= '0;
      positive_count   <= '0;
      negative_count   <= '0;
      samples_in_block <= '0;
      blocks_done      <= '0;
    end else begin
      positive_sum     <= positive_sum_next;
      negative_sum     <= negative_sum_next;
      positive_count   <= positive_count_next;
      negative_count   <= negative_count_next;
      samples_in_block <= samples_in_block_next;
      blocks_done      <= blocks_done_next;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and divider requests
  always_comb begin
    state_next     = state;
    div_req.start  = 1'b0;
    div_req.negate = 1'b0;
    div_dividend   = positive_sum;
    div_divisor    = positive_count;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if ((blk_base < BLK_CNT_W'(BLOCKS)) && (samples_in_block_next >= bsize)) begin
          state_next = S_POS_GO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POS_GO: begin
        div_req.start = 1'b1;
        state_next    = S_POS_DIV;
      end
      S_POS_DIV: begin
        if (div_stat.done) begin
          state_next = S_POS_OUT;
        end
      end
      S_POS_OUT: begin
        if (out_ready) begin
          state_next = S_NEG_GO;
        end
      end
      S_NEG_GO: begin
        div_req.start  = 1'b1;
        div_req.negate = 1'b1;
        div_dividend   = negative_sum;
        div_divisor    = negative_count;
        state_next     = S_NEG_DIV;
      end
      S_NEG_DIV: begin
        if (div_stat.done) begin
          state_next = S_NEG_OUT;
        end
      end
      S_NEG_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // shared divider for both halves
  wfpnm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .result   (div_result)
  );

  // outputs, held steady by the waiting states
  assign in_ready         = (state == S_IDLE);
  assign out_valid        = (state == S_POS_OUT) || (state == S_NEG_OUT);
  assign mean             = div_result;
  assign is_negative_half = (state == S_NEG_OUT);
  assign last             = (state == S_NEG_OUT);
  assign block_index      = BLK_IDX_W'(blocks_done);
  assign block_size_out   = bsize[CNT_W-1:BSIZE_OUT_W] != '0 ? '1 : bsize[BSIZE_OUT_W-1:0];
  assign waveform_done    = (blocks_done == BLK_CNT_W'(BLOCKS - 1));

  assign out_xfer = out_valid && out_ready;

  // checks
  `WFPNM_ASSERT_SAME(a_no_accept_while_out, clk, rst, out_valid, !in_ready && !div_stat.busy)
  `WFPNM_ASSERT_NEXT(a_pair_end_ready, clk, rst, out_xfer && last, in_ready)
  `WFPNM_ASSERT_NEXT(a_first_half_then_divide, clk, rst, out_xfer && !last, !out_valid)
  `WFPNM_ASSERT_SAME(a_blocks_in_range, clk, rst, 1'b1, blocks_done <= BLK_CNT_W'(BLOCKS))

endmodule

// ===== rtl/core/wfpnm_div.sv =====
// ----------------------------------------------------------------------------
// wfpnm_div
// restoring divider, one quotient bit a cycle, signed result truncated to zero
// ----------------------------------------------------------------------------
module wfpnm_div import wfpnm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  div_req_t                 req,
  input  logic signed [SUM_W-1:0]  dividend,
  input  logic        [CNT_W-1:0]  divisor,
  output div_stat_t                stat,
  output logic signed [MEAN_W-1:0] result
);

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dsh;
  logic [MEAN_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic              negate;
  logic              zero_div;
  logic              busy;
  logic              done;

  logic [SUM_W:0]    diff;
  logic [MEAN_W-1:0] quo_next;

  // one trial subtraction of the shifted divisor
  always_comb begin
    diff = {1'b0, rem} - {1'b0, dsh};
    if (!diff[SUM_W]) begin
      quo_next = {quo[MEAN_W-2:0], 1'b1};
    end else begin
      quo_next = {quo[MEAN_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= req.negate ? (SUM_W'(0) - dividend) : dividend;
      dsh      <= SUM_W'(divisor) << (MEAN_W - 1);
      quo      <= '0;
      step     <= STEP_W'(MEAN_W - 1);
      negate   <= req.negate;
      zero_div <= (divisor == '0);
    end else if (busy) begin
      if (!diff[SUM_W]) begin
        rem <= diff[SUM_W-1:0];
      end
      dsh  <= dsh >> 1;
      quo  <= quo_next;
      step <= step - STEP_W'(1);
      // last step: fix sign, empty half reads as zero
      if (step == '0) begin
        if (zero_div) begin
          result <= '0;
        end else if (negate) begin
          result <= MEAN_W'(0) - quo_next;
        end else begin
          result <= quo_next;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
